// ----- src/midi_timecode_message_decoder_assert.svh -----
// Assertion macros for the MIDI time code message decoder.
// Expects i_clk and i_rst_n in the scope of the including module.
`ifndef MIDI_TIMECODE_MESSAGE_DECODER_ASSERT_SVH
`define MIDI_TIMECODE_MESSAGE_DECODER_ASSERT_SVH

// Check that cond_a implies cond_b in the same cycle.
`define MTCD_ASSERT_SAME(label, cond_a, cond_b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |-> (cond_b)) else $error("mtcd same-cycle check failed");

// Check that cond_a implies cond_b in the next cycle.
`define MTCD_ASSERT_NEXT(label, cond_a, cond_b) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond_a) |=> (cond_b)) else $error("mtcd next-cycle check failed");

`endif

// ----- src/mtcd_pkg.sv -----
// Package for the MIDI time code message decoder: word types, message
// constants, event codes and the rate field mapping. No dependencies.
package mtcd_pkg;

    localparam int BufDepth = 11;
    localparam logic [3:0] CountMax = 4'd15;

    localparam logic [2:0] EV_TIMECODE = 3'd0;
    localparam logic [2:0] EV_QUARTER  = 3'd1;
    localparam logic [2:0] EV_PLAY     = 3'd2;
    localparam logic [2:0] EV_STOP     = 3'd3;
    localparam logic [2:0] EV_BAD      = 3'd4;
    localparam logic [2:0] EV_IGNORED  = 3'd5;

    localparam logic [7:0] ST_SYSEX       = 8'hF0;
    localparam logic [7:0] ST_QUARTER     = 8'hF1;
    localparam logic [7:0] ID_UNIVERSAL   = 8'h7F;
    localparam logic [7:0] TYPE_TIMECODE  = 8'h01;
    localparam logic [7:0] TYPE_MMC       = 8'h06;
    localparam logic [7:0] TC_FULL        = 8'h01;
    localparam logic [7:0] MMC_STOP       = 8'h01;
    localparam logic [7:0] MMC_PLAY       = 8'h02;
    localparam logic [7:0] MMC_LOCATE     = 8'h44;

    localparam logic [3:0] LEN_MIN_SYSEX  = 4'd4;
    localparam logic [3:0] LEN_TIMECODE   = 4'd10;
    localparam logic [3:0] LEN_MIN_MMC    = 4'd5;
    localparam logic [3:0] LEN_MIN_LOCATE = 4'd11;
    localparam logic [3:0] LEN_QUARTER    = 4'd2;

    localparam logic [2:0] RATE_2398  = 3'd0;
    localparam logic [2:0] RATE_24    = 3'd1;
    localparam logic [2:0] RATE_25    = 3'd2;
    localparam logic [2:0] RATE_2997  = 3'd3;
    localparam logic [2:0] RATE_30    = 3'd4;
    localparam logic [2:0] RATE_RESET = RATE_25;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       end_of_message;
    } t_in_word;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [4:0] hours;
        logic [7:0] minutes;
        logic [7:0] seconds;
        logic [7:0] frames;
        logic [2:0] rate_code;
        logic [7:0] quarter_data;
    } t_out_word;

    function automatic logic [2:0] rate_from_field(input logic [2:0] field,
                                                   input logic       as_2398);
        logic [2:0] rate;
        unique case (field)
            3'd0:    rate = as_2398 ? RATE_2398 : RATE_24;
            3'd1:    rate = RATE_25;
            3'd2:    rate = RATE_2997;
            3'd3:    rate = RATE_30;
            default: rate = RATE_25;
        endcase
        return rate;
    endfunction

endpackage

// ----- src/midi_timecode_message_decoder.sv -----
// MIDI time code message decoder: one MIDI byte per cycle in, one decoded
// result word out on the last byte of each message. Uses mtcd_pkg and the
// assertion macro header.
// The result word is registered: in the output register, or in the skid register while the output stalls.
// Throughput: one byte per cycle; input stalls only when the output register
// and the skid register both hold unread words.
// Reset (synchronous): count cleared, time code 00:00:00:00 at 25 fps,
// rate option cleared; the byte buffer is not cleared.
`include "midi_timecode_message_decoder_assert.svh"

module midi_timecode_message_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  mtcd_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mtcd_pkg::t_out_word o_out_word
);

    logic       r_as_2398;
    logic [3:0] r_count;
    logic [7:0] r_buf [0:mtcd_pkg::BufDepth-1];
    logic [4:0] r_hours;
    logic [7:0] r_minutes;
    logic [7:0] r_seconds;
    logic [7:0] r_frames;
    logic [2:0] r_rate;

    logic                r_out_valid;
    logic                r_skid_valid;
    mtcd_pkg::t_out_word r_out_word;
    mtcd_pkg::t_out_word r_skid_word;

    logic       in_acc;
    logic       res_valid;
    logic       out_free;
    logic [3:0] n_count;
    logic [3:0] len;
    logic [7:0] v_buf [0:mtcd_pkg::BufDepth-1];
    logic [4:0] n_hours;
    logic [7:0] n_minutes;
    logic [7:0] n_seconds;
    logic [7:0] n_frames;
    logic [2:0] n_rate;
    logic [2:0] n_kind;
    logic [7:0] n_qdata;
    logic       ld_en;
    logic [7:0] ld_hb;
    logic [7:0] ld_mb;
    logic [7:0] ld_sb;
    logic [7:0] ld_fb;
    mtcd_pkg::t_out_word n_res;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign res_valid = in_acc && i_in_word.end_of_message;
    assign out_free  = !r_out_valid || !i_out_stall;

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        for (int k = 0; k < mtcd_pkg::BufDepth; k++) begin
            if (r_count == 4'(k)) begin
                v_buf[k] = i_in_word.msg_byte;
            end else begin
                v_buf[k] = r_buf[k];
            end
        end
        len = (r_count == mtcd_pkg::CountMax) ? r_count : r_count + 4'd1;
        if (i_in_word.end_of_message) begin
            n_count = 4'd0;
        end else begin
            n_count = len;
        end
    end

    always_comb begin
        n_hours   = r_hours;
        n_minutes = r_minutes;
        n_seconds = r_seconds;
        n_frames  = r_frames;
        n_rate    = r_rate;
        n_kind    = mtcd_pkg::EV_BAD;
        n_qdata   = 8'd0;
        ld_en     = 1'b0;
        ld_hb     = v_buf[5];
        ld_mb     = v_buf[6];
        ld_sb     = v_buf[7];
        ld_fb     = v_buf[8];

        priority if (v_buf[0] == mtcd_pkg::ST_SYSEX) begin
            priority if (len < mtcd_pkg::LEN_MIN_SYSEX) begin
                n_kind = mtcd_pkg::EV_BAD;
            end else if (v_buf[1] != mtcd_pkg::ID_UNIVERSAL) begin
                n_kind = mtcd_pkg::EV_IGNORED;
            end else if (v_buf[3] == mtcd_pkg::TYPE_TIMECODE) begin
                if (len == mtcd_pkg::LEN_TIMECODE && v_buf[4] == mtcd_pkg::TC_FULL) begin
                    ld_en  = 1'b1;
                    n_kind = mtcd_pkg::EV_TIMECODE;
                end
            end else if (v_buf[3] == mtcd_pkg::TYPE_MMC) begin
                priority if (len < mtcd_pkg::LEN_MIN_MMC) begin
                    n_kind = mtcd_pkg::EV_BAD;
                end else if (v_buf[4] == mtcd_pkg::MMC_STOP) begin
                    n_kind = mtcd_pkg::EV_STOP;
                end else if (v_buf[4] == mtcd_pkg::MMC_PLAY) begin
                    n_kind = mtcd_pkg::EV_PLAY;
                end else if (v_buf[4] == mtcd_pkg::MMC_LOCATE) begin
                    if (len >= mtcd_pkg::LEN_MIN_LOCATE) begin
                        ld_en  = 1'b1;
                        ld_hb  = v_buf[7];
                        ld_mb  = v_buf[8];
                        ld_sb  = v_buf[9];
                        ld_fb  = {3'd0, v_buf[10][4:0]};
                        n_kind = mtcd_pkg::EV_TIMECODE;
                    end
                end else begin
                    n_kind = mtcd_pkg::EV_BAD;
                end
            end else begin
                n_kind = mtcd_pkg::EV_BAD;
            end
        end else if (v_buf[0] == mtcd_pkg::ST_QUARTER) begin
            if (len == mtcd_pkg::LEN_QUARTER) begin
                n_kind  = mtcd_pkg::EV_QUARTER;
                n_qdata = v_buf[1];
                unique case (v_buf[1][7:4])
                    4'd0: n_frames  = {r_frames[7:4], v_buf[1][3:0]};
                    4'd1: n_frames  = {v_buf[1][3:0], r_frames[3:0]};
                    4'd2: n_seconds = {r_seconds[7:4], v_buf[1][3:0]};
                    4'd3: n_seconds = {v_buf[1][3:0], r_seconds[3:0]};
                    4'd4: n_minutes = {r_minutes[7:4], v_buf[1][3:0]};
                    4'd5: n_minutes = {v_buf[1][3:0], r_minutes[3:0]};
                    4'd6: n_hours   = {r_hours[4], v_buf[1][3:0]};
                    4'd7: begin
                        n_hours = {v_buf[1][0], r_hours[3:0]};
                        n_rate  = mtcd_pkg::rate_from_field({1'b0, v_buf[1][2:1]},
                                                            r_as_2398);
                    end
                    default: n_hours = r_hours;
                endcase
            end
        end else begin
            n_kind = mtcd_pkg::EV_BAD;
        end

        if (ld_en) begin
            n_rate    = mtcd_pkg::rate_from_field(ld_hb[7:5], r_as_2398);
            n_hours   = ld_hb[4:0];
            n_minutes = ld_mb;
            n_seconds = ld_sb;
            n_frames  = ld_fb;
        end

        n_res.event_kind   = n_kind;
        n_res.hours        = n_hours;
        n_res.minutes      = n_minutes;
        n_res.seconds      = n_seconds;
        n_res.frames       = n_frames;
        n_res.rate_code    = n_rate;
        n_res.quarter_data = n_qdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_as_2398 <= 1'b0;
            r_count   <= 4'd0;
            r_hours   <= 5'd0;
            r_minutes <= 8'd0;
            r_seconds <= 8'd0;
            r_frames  <= 8'd0;
            r_rate    <= mtcd_pkg::RATE_RESET;
        end else begin
            if (i_cfg_we) begin
                r_as_2398 <= i_cfg_data;
            end
            if (in_acc) begin
                r_count <= n_count;
            end
            if (res_valid) begin
                r_hours   <= n_hours;
                r_minutes <= n_minutes;
                r_seconds <= n_seconds;
                r_frames  <= n_frames;
                r_rate    <= n_rate;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int k = 0; k < mtcd_pkg::BufDepth; k++) begin
                if (r_count == 4'(k)) begin
                    r_buf[k] <= i_in_word.msg_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_word <= r_skid_valid ? r_skid_word : n_res;
        end else if (res_valid) begin
            r_skid_word <= n_res;
        end
    end

    `MTCD_ASSERT_SAME(a_skid_implies_out, r_skid_valid, r_out_valid)
    `MTCD_ASSERT_NEXT(a_count_clears, res_valid, r_count == 4'd0)
    `MTCD_ASSERT_NEXT(a_no_spurious_word, in_acc && !i_in_word.end_of_message && !r_out_valid, !r_out_valid)
    `MTCD_ASSERT_SAME(a_kind_range, r_out_valid, r_out_word.event_kind <= mtcd_pkg::EV_IGNORED)

endmodule
